>>> rtl/sdf_pkg.sv
package sdf_pkg;

   // default number of entries in the exclusion store
   localparam int STORE_DEPTH_DEFAULT = 1024;

   // field widths
   localparam int OP_W    = 2;
   localparam int VALUE_W = 32;

   // operation codes of an input word
   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_LAST
   } state_type;

endpackage

>>> rtl/sdf_store.sv
module sdf_store #(
   parameter int STORE_DEPTH = sdf_pkg::STORE_DEPTH_DEFAULT,
   parameter int AW          = $clog2(STORE_DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [sdf_pkg::VALUE_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [sdf_pkg::VALUE_W-1:0] rd_data
);

   logic [sdf_pkg::VALUE_W-1:0] store_mem [STORE_DEPTH];
   logic [sdf_pkg::VALUE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sdf_ctrl.sv
module sdf_ctrl #(
   parameter int STORE_DEPTH = sdf_pkg::STORE_DEPTH_DEFAULT,
   parameter int AW          = $clog2(STORE_DEPTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sdf_pkg::OP_W-1:0]    req_operation,
   input  logic [sdf_pkg::VALUE_W-1:0] req_item_value,
   output logic                        busy,
   output logic                        rsp_valid,
   output logic [sdf_pkg::VALUE_W-1:0] rsp_kept_value,
   output logic                        mem_wr_en,
   output logic [AW-1:0]               mem_wr_addr,
   output logic [sdf_pkg::VALUE_W-1:0] mem_wr_data,
   output logic [AW-1:0]               mem_rd_addr,
   input  logic [sdf_pkg::VALUE_W-1:0] mem_rd_data
);

   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam logic [AW-1:0] ONE_A = AW'(1);
   localparam logic [CW-1:0] ONE_C = CW'(1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

   sdf_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [AW-1:0] mid_ff, mid_in;
   logic [sdf_pkg::VALUE_W-1:0] value_ff, value_in;
   logic match_ff, match_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [sdf_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic accept;
   logic le;
   logic gt;
   logic hit;
   logic [CW-1:0] lo_step;
   logic [CW-1:0] hi_step;
   logic [CW-1:0] mid_step;
   logic search_end;
   logic final_match;

   assign accept = start && (state_ff == sdf_pkg::ST_IDLE);
   assign busy   = (state_ff != sdf_pkg::ST_IDLE);

   // compare of the word just read against the held value
   assign le  = ($signed(mem_rd_data) <= $signed(value_ff));
   assign gt  = !le;
   assign hit = (mem_rd_data == value_ff);

   // one binary search step, upper bound form
   assign lo_step    = le ? (CW'(mid_ff) + ONE_C) : lo_ff;
   assign hi_step    = le ? hi_ff : CW'(mid_ff);
   assign mid_step   = lo_step + ((hi_step - lo_step) >> 1);
   assign search_end = (lo_step >= hi_step);
   // the entry below the upper bound is the last one that moved lo
   assign final_match = le ? hit : match_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sdf_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  sdf_pkg::OP_LOAD: begin
                     if ((count_ff < DEPTH_C) && (count_ff != '0)) begin
                        state_in = sdf_pkg::ST_SHIFT;
                     end
                  end
                  sdf_pkg::OP_QUERY: begin
                     if (count_ff != '0) begin
                        state_in = sdf_pkg::ST_SEARCH;
                     end
                  end
                  default: state_in = sdf_pkg::ST_IDLE;
               endcase
            end
         end
         sdf_pkg::ST_SEARCH: begin
            if (search_end) begin
               state_in = sdf_pkg::ST_IDLE;
            end
         end
         sdf_pkg::ST_SHIFT: begin
            if (!gt) begin
               state_in = sdf_pkg::ST_IDLE;
            end else if (mid_ff == '0) begin
               state_in = sdf_pkg::ST_LAST;
            end
         end
         sdf_pkg::ST_LAST: state_in = sdf_pkg::ST_IDLE;
         default: state_in = sdf_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory requests
   always_comb begin
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      value_in     = value_ff;
      match_in     = match_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = mid_ff + ONE_A;
      mem_wr_data  = mem_rd_data;
      mem_rd_addr  = mid_ff;
      case (state_ff)
         sdf_pkg::ST_IDLE: begin
            if (accept) begin
               value_in = req_item_value;
               match_in = 1'b0;
               case (req_operation)
                  sdf_pkg::OP_LOAD: begin
                     // a load into a full store is dropped
                     if (count_ff < DEPTH_C) begin
                        count_in = count_ff + ONE_C;
                        if (count_ff == '0) begin
                           mem_wr_en   = 1'b1;
                           mem_wr_addr = '0;
                           mem_wr_data = req_item_value;
                        end else begin
                           mem_rd_addr = AW'(count_ff - ONE_C);
                           mid_in      = AW'(count_ff - ONE_C);
                        end
                     end
                  end
                  sdf_pkg::OP_QUERY: begin
                     lo_in       = '0;
                     hi_in       = count_ff;
                     mem_rd_addr = AW'(count_ff >> 1);
                     mid_in      = AW'(count_ff >> 1);
                     // empty store keeps every value
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_value_in = req_item_value;
                     end
                  end
                  sdf_pkg::OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: count_in = count_ff;
               endcase
            end
         end
         sdf_pkg::ST_SEARCH: begin
            lo_in       = lo_step;
            hi_in       = hi_step;
            mem_rd_addr = AW'(mid_step);
            mid_in      = AW'(mid_step);
            if (le) begin
               match_in = hit;
            end
            if (search_end && !final_match) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_ff;
            end
         end
         sdf_pkg::ST_SHIFT: begin
            // move a larger entry up one place, or drop the new word in
            mem_wr_en = 1'b1;
            if (gt) begin
               mem_wr_data = mem_rd_data;
               mem_rd_addr = mid_ff - ONE_A;
               mid_in      = mid_ff - ONE_A;
            end else begin
               mem_wr_data = value_ff;
            end
         end
         sdf_pkg::ST_LAST: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = '0;
            mem_wr_data = value_ff;
         end
         default: mem_wr_en = 1'b0;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sdf_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      value_ff     <= value_in;
      match_ff     <= match_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kept_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count beyond store depth");

   a_search_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdf_pkg::ST_SEARCH) |-> (lo_ff < hi_ff))
      else $error("search range empty while searching");

   a_shift_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sdf_pkg::ST_SHIFT) |-> ((CW'(mid_ff) + ONE_C) < count_ff))
      else $error("shift writes beyond the filled part of the store");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == sdf_pkg::ST_IDLE))
      else $error("result strobe while still busy");
`endif

endmodule

>>> rtl/set_difference_filter.sv
// query: a binary search over the n stored entries, from start to the result strobe;
//   one store read per search step
// load: written directly into an empty store, else one larger entry moved up per cycle
// clear and unused codes leave busy low; a new word is taken once busy is low
// synchronous reset empties the store and drops any pending result; the store itself is not cleared
// the result strobe lasts one cycle and the receiver cannot stall it
module set_difference_filter #(
   parameter int STORE_DEPTH = sdf_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [sdf_pkg::OP_W-1:0]    req_operation,
   input  logic [sdf_pkg::VALUE_W-1:0] req_item_value,
   output logic                        rsp_valid,
   output logic [sdf_pkg::VALUE_W-1:0] rsp_kept_value
);

   localparam int AW = $clog2(STORE_DEPTH);

   logic                        mem_wr_en;
   logic [AW-1:0]               mem_wr_addr;
   logic [sdf_pkg::VALUE_W-1:0] mem_wr_data;
   logic [AW-1:0]               mem_rd_addr;
   logic [sdf_pkg::VALUE_W-1:0] mem_rd_data;

   // search and insertion sequencer
   sdf_ctrl #(
      .STORE_DEPTH (STORE_DEPTH),
      .AW          (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_operation  (req_operation),
      .req_item_value (req_item_value),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_kept_value (rsp_kept_value),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   // sorted exclusion store
   sdf_store #(
      .STORE_DEPTH (STORE_DEPTH),
      .AW          (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

>>> dv/tb_set_difference_filter.sv
module tb_set_difference_filter;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH  = sdf_pkg::STORE_DEPTH_DEFAULT;
   localparam int RANDOM_WORDS = 700;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1000000;

   localparam logic [sdf_pkg::VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
   localparam logic [sdf_pkg::VALUE_W-1:0] VALUE_MAX = 32'h7fff_ffff;
   // code outside the operation set, which the block ignores
   localparam logic [sdf_pkg::OP_W-1:0]    OP_UNUSED = 2'd3;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [sdf_pkg::OP_W-1:0]    req_operation;
   logic [sdf_pkg::VALUE_W-1:0] req_item_value;
   logic                        rsp_valid;
   logic [sdf_pkg::VALUE_W-1:0] rsp_kept_value;

   // own copy of the exclusion store, kept ascending
   logic signed [sdf_pkg::VALUE_W-1:0] excluded_values[$];
   // query values expected to pass, oldest first
   logic signed [sdf_pkg::VALUE_W-1:0] kept_expected[$];
   logic signed [sdf_pkg::VALUE_W-1:0] kept_oldest;

   int error_count = 0;
   int cycle_count = 0;
   int burst_left  = 0;
   int burst_max   = 4;
   int gap_max     = 3;

   set_difference_filter #(
      .STORE_DEPTH(STORE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_item_value(req_item_value),
      .rsp_valid(rsp_valid),
      .rsp_kept_value(rsp_kept_value)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_set_difference_filter failed");
         $finish;
      end
   end

   // effect of one accepted word on the store and the expected output
   function automatic void filter_word(input logic [sdf_pkg::OP_W-1:0] op,
                                       input logic signed [sdf_pkg::VALUE_W-1:0] value);
      int  pos;
      bit  found;
      pos   = 0;
      found = 1'b0;
      case (op)
         sdf_pkg::OP_LOAD: begin
            // a full store drops the value
            if (excluded_values.size() < STORE_DEPTH) begin
               while (pos < excluded_values.size() && excluded_values[pos] <= value)
                  pos++;
               excluded_values.insert(pos, value);
            end
         end
         sdf_pkg::OP_QUERY: begin
            foreach (excluded_values[i])
               if (excluded_values[i] == value)
                  found = 1'b1;
            if (!found)
               kept_expected.push_back(value);
         end
         sdf_pkg::OP_CLEAR: excluded_values.delete();
         default: ;
      endcase
   endfunction

   // one word to the block, with bursts and gaps on the sending side
   task automatic send_word(input logic [sdf_pkg::OP_W-1:0] op,
                            input logic [sdf_pkg::VALUE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
         repeat (gap) begin
            @(negedge clock);
            start <= 1'b0;
         end
         burst_left = $urandom_range(burst_max, 1);
      end
      burst_left--;
      @(negedge clock);
      start          <= 1'b1;
      req_operation  <= op;
      req_item_value <= value;
      do @(posedge clock); while (busy !== 1'b0);
      filter_word(op, value);
   endtask

   // hold the sender until every expected word has come out
   task automatic wait_for_results();
      @(negedge clock);
      start <= 1'b0;
      while (kept_expected.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // compare each output word with the oldest expectation
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) begin
         if (kept_expected.size() == 0) begin
            $error("kept_value: expected none, actual %0d", $signed(rsp_kept_value));
            error_count++;
         end else begin
            kept_oldest = kept_expected.pop_front();
            if (rsp_kept_value !== kept_oldest) begin
               $error("kept_value: expected %0d, actual %0d",
                      kept_oldest, $signed(rsp_kept_value));
               error_count++;
            end
         end
      end
   end

   // queries on an empty store all pass
   task automatic test_empty_store();
      burst_max = 2;
      gap_max   = 3;
      send_word(sdf_pkg::OP_QUERY, VALUE_MIN);
      send_word(sdf_pkg::OP_QUERY, VALUE_MAX);
      send_word(sdf_pkg::OP_QUERY, 32'd0);
      send_word(sdf_pkg::OP_QUERY, 32'hffff_ffff);
   endtask

   // extremes, duplicates, neighbours and the unused code
   task automatic test_load_and_query();
      send_word(sdf_pkg::OP_LOAD, VALUE_MIN);
      send_word(sdf_pkg::OP_LOAD, VALUE_MAX);
      send_word(sdf_pkg::OP_LOAD, 32'd0);
      send_word(sdf_pkg::OP_LOAD, 32'hffff_ffff);
      send_word(sdf_pkg::OP_LOAD, 32'd5);
      send_word(sdf_pkg::OP_LOAD, 32'd5);
      send_word(sdf_pkg::OP_QUERY, VALUE_MIN);
      send_word(sdf_pkg::OP_QUERY, VALUE_MAX);
      send_word(sdf_pkg::OP_QUERY, 32'd0);
      send_word(sdf_pkg::OP_QUERY, 32'hffff_ffff);
      send_word(sdf_pkg::OP_QUERY, 32'd5);
      send_word(sdf_pkg::OP_QUERY, VALUE_MIN + 32'd1);
      send_word(sdf_pkg::OP_QUERY, VALUE_MAX - 32'd1);
      send_word(sdf_pkg::OP_QUERY, 32'd1);
      send_word(sdf_pkg::OP_QUERY, 32'd4);
      send_word(sdf_pkg::OP_QUERY, 32'd6);
      // ignored code must not load its value
      send_word(OP_UNUSED, 32'd9);
      send_word(sdf_pkg::OP_QUERY, 32'd9);
   endtask

   // clear empties the store, also when already empty
   task automatic test_clear();
      send_word(sdf_pkg::OP_CLEAR, 32'hdead_beef);
      send_word(sdf_pkg::OP_QUERY, 32'd5);
      send_word(sdf_pkg::OP_QUERY, VALUE_MAX);
      send_word(sdf_pkg::OP_CLEAR, 32'd0);
      send_word(sdf_pkg::OP_QUERY, 32'd0);
   endtask

   // fill every entry, then loads past capacity are dropped
   task automatic test_full_store();
      logic [sdf_pkg::VALUE_W-1:0] v;
      burst_max = 16;
      gap_max   = 2;
      send_word(sdf_pkg::OP_CLEAR, 32'd0);
      for (int i = 0; i < STORE_DEPTH - 1; i++) begin
         v = {i[9:0], 22'd0} ^ VALUE_MIN;
         send_word(sdf_pkg::OP_LOAD, v);
      end
      send_word(sdf_pkg::OP_LOAD, VALUE_MAX);
      send_word(sdf_pkg::OP_LOAD, 32'd7);
      send_word(sdf_pkg::OP_LOAD, VALUE_MIN + 32'd1);
      send_word(sdf_pkg::OP_QUERY, 32'd7);
      send_word(sdf_pkg::OP_QUERY, VALUE_MIN + 32'd1);
      send_word(sdf_pkg::OP_QUERY, VALUE_MIN);
      send_word(sdf_pkg::OP_QUERY, VALUE_MAX);
      send_word(sdf_pkg::OP_QUERY, 32'd0);
      send_word(sdf_pkg::OP_QUERY, 32'd1);
      wait_for_results();
      send_word(sdf_pkg::OP_CLEAR, 32'd0);
      send_word(sdf_pkg::OP_QUERY, 32'd0);
   endtask

   // rounds of clear, loads and queries with random content
   task automatic test_random();
      logic signed [sdf_pkg::VALUE_W-1:0] loaded[$];
      logic signed [sdf_pkg::VALUE_W-1:0] v;
      int sent;
      int pick;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         // idling pattern for this round, sometimes none at all
         burst_max = $urandom_range(10, 1);
         gap_max   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
         if ($urandom_range(4, 0) != 0) begin
            send_word(sdf_pkg::OP_CLEAR, $urandom);
            loaded.delete();
            sent++;
         end
         repeat ($urandom_range(24, 0)) begin
            pick = $urandom_range(9, 0);
            if (pick < 4)
               v = $urandom_range(15, 0) - 8;
            else if (pick == 4)
               v = $urandom_range(1, 0) ? VALUE_MIN : VALUE_MAX;
            else
               v = $urandom;
            send_word(sdf_pkg::OP_LOAD, v);
            loaded.push_back(v);
            sent++;
         end
         repeat ($urandom_range(30, 4)) begin
            pick = $urandom_range(9, 0);
            if (pick < 5 && loaded.size() > 0)
               v = loaded[$urandom_range(loaded.size() - 1, 0)];
            else if (pick < 7 && loaded.size() > 0)
               v = loaded[$urandom_range(loaded.size() - 1, 0)]
                   + ($urandom_range(1, 0) ? 1 : -1);
            else if (pick < 8)
               v = $urandom_range(15, 0) - 8;
            else
               v = $urandom;
            send_word(sdf_pkg::OP_QUERY, v);
            sent++;
            // noise: ignored code, or a clear in mid round
            if ($urandom_range(15, 0) == 0)
               send_word(OP_UNUSED, $urandom);
            if ($urandom_range(40, 0) == 0) begin
               send_word(sdf_pkg::OP_CLEAR, $urandom);
               loaded.delete();
               sent++;
            end
         end
         if ($urandom_range(5, 0) == 0)
            wait_for_results();
      end
   endtask

   // sequence of tests
   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_operation  = sdf_pkg::OP_LOAD;
      req_item_value = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_store();
      test_load_and_query();
      wait_for_results();
      test_clear();
      test_full_store();
      wait_for_results();
      test_random();
      wait_for_results();

      if (error_count == 0)
         $display("tb_set_difference_filter passed");
      else
         $display("tb_set_difference_filter failed");
      $finish;
   end

endmodule
